// File: src/gsr_pkg.sv
// ----------------------------------------------------------------------------
// gsr_pkg: shared types and constants of the glyph string rasterizer
// Modes, register indexes, field widths and the job record that passes from
// the front part to the back part.
// ----------------------------------------------------------------------------
package gsr_pkg;

    localparam int GLYPH_BYTES_DEF = 4096;
    localparam int CHAR_COUNT      = 128;
    localparam int MAX_ROWS_DEF    = 16;

    localparam logic [2:0] MODE_LOAD_WIDTH  = 3'd0;
    localparam logic [2:0] MODE_LOAD_OFFSET = 3'd1;
    localparam logic [2:0] MODE_LOAD_BYTE   = 3'd2;
    localparam logic [2:0] MODE_BEGIN       = 3'd3;
    localparam logic [2:0] MODE_DRAW        = 3'd4;

    localparam logic [2:0] REG_COLOR_MAP   = 3'd0;
    localparam logic [2:0] REG_START_X     = 3'd1;
    localparam logic [2:0] REG_START_Y     = 3'd2;
    localparam logic [2:0] REG_SPAN_WIDTH  = 3'd3;
    localparam logic [2:0] REG_SPACE_WIDTH = 3'd4;
    localparam logic [2:0] REG_SURF_WIDTH  = 3'd5;
    localparam logic [2:0] REG_SURF_HEIGHT = 3'd6;
    localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd7;

    localparam logic signed [12:0] PEN_MIN = -13'sd2048;
    localparam logic signed [12:0] PEN_MAX = 13'sd4095;

    localparam logic [31:0] COLOR_MAP_RST = 32'h0807_0FFF;
    localparam logic [10:0] SURF_W_RST    = 11'd320;
    localparam logic [10:0] SURF_H_RST    = 11'd200;
    localparam logic [4:0]  GLYPH_H_RST   = 5'd16;

    // job handed from front to back
    typedef struct packed {
        logic              status;   // single status result only
        logic              stopped;
        logic signed [12:0] pen;     // pen after this item
        logic signed [12:0] x0;      // glyph left column
        logic [9:0]        y0;       // first visible row
        logic [4:0]        height;   // visible rows
        logic [4:0]        cw;       // glyph width
        logic [2:0]        bpp;      // bytes per row
        logic [17:0]       base;     // first byte address, unwrapped
    } gsr_job_t;

endpackage

// File: src/gsr_if.sv
// ----------------------------------------------------------------------------
// gsr_in_if / gsr_out_if: valid-ready channels of the rasterizer
// Input items carry mode, index and value; results carry pixels and status.
// ----------------------------------------------------------------------------
interface gsr_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [11:0] index;
    logic [11:0] value;
    modport source (output valid, mode, index, value, input ready);
    modport sink   (input valid, mode, index, value, output ready);
endinterface

interface gsr_out_if;
    logic               valid;
    logic               ready;
    logic [9:0]         pixel_x;
    logic [9:0]         pixel_y;
    logic [31:0]        pixels;
    logic [3:0]         write_mask;
    logic signed [12:0] pen_x;
    logic               stopped;
    logic               last;
    modport source (output valid, pixel_x, pixel_y, pixels, write_mask, pen_x,
                    stopped, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixels, write_mask, pen_x,
                    stopped, last, output ready);
endinterface

// File: src/gsr_ram.sv
// ----------------------------------------------------------------------------
// gsr_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: src/gsr_front.sv
// ----------------------------------------------------------------------------
// gsr_front: accepts items, does loads, clipping and pen update
// A draw reads the width and offset tables (registered reads), then builds a job.
// ----------------------------------------------------------------------------
module gsr_front
    import gsr_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    gsr_in_if.sink             in_ch,
    input  logic signed [10:0] start_x,
    input  logic signed [10:0] start_y,
    input  logic [9:0]         span_width,
    input  logic signed [5:0]  space_width,
    input  logic [10:0]        surface_width,
    input  logic [10:0]        surface_height,
    input  logic [4:0]         glyph_height,
    input  logic               store_idle,
    output logic               byte_we,
    output logic [11:0]        byte_waddr,
    output logic [7:0]         byte_wdata,
    output logic               job_valid,
    input  logic               job_ready,
    output gsr_job_t           job
);
    localparam logic [4:0] MAX_ROWS_C = 5'(MAX_ROWS);

    logic               pend_reg, pend_next;
    logic signed [12:0] pen_reg, pen_next;
    logic               halt_reg, halt_next;
    logic [6:0]         rd_char;
    logic [4:0]         w_rdata;
    logic [11:0]        o_rdata;
    logic               acc;

    // a draw waits for the registered table reads; hold a byte load until
    // no queued or running glyph still reads the store
    assign in_ch.ready = !pend_reg && job_ready &&
                         (in_ch.mode != MODE_LOAD_BYTE || store_idle);
    assign acc = in_ch.valid && in_ch.ready;
    assign rd_char = in_ch.index[6:0];

    assign byte_we    = acc && in_ch.mode == MODE_LOAD_BYTE;
    assign byte_waddr = in_ch.index;
    assign byte_wdata = in_ch.value[7:0];

    gsr_ram #(.WIDTH(5), .DEPTH(CHAR_COUNT)) u_width (
        .clk(clk), .we(acc && in_ch.mode == MODE_LOAD_WIDTH),
        .waddr(in_ch.index[6:0]), .wdata(in_ch.value[4:0]),
        .raddr(rd_char), .rdata(w_rdata)
    );
    gsr_ram #(.WIDTH(12), .DEPTH(CHAR_COUNT)) u_offset (
        .clk(clk), .we(acc && in_ch.mode == MODE_LOAD_OFFSET),
        .waddr(in_ch.index[6:0]), .wdata(in_ch.value),
        .raddr(rd_char), .rdata(o_rdata)
    );

    // clipping terms, from configuration only
    logic signed [12:0] sx, xend, ylim;
    logic signed [12:0] y_s;
    logic [4:0]         hcell, skip5, h_a, vis;
    logic [10:0]        y_top;
    logic signed [12:0] bottom, room;
    always_comb
    begin
        sx   = 13'(start_x);
        xend = $signed({2'b0, surface_width});
        if (span_width != 10'd0 &&
            sx + $signed({3'b0, span_width}) < $signed({2'b0, surface_width}))
        begin
            xend = sx + $signed({3'b0, span_width});
        end
        hcell = (glyph_height > MAX_ROWS_C) ? MAX_ROWS_C : glyph_height;
        y_s   = 13'(start_y);
        skip5 = 5'd0;
        y_top = 11'(start_y);
        h_a   = hcell;
        if (start_y < 0)
        begin
            y_top = 11'd0;
            if (y_s < -13'sd16)
            begin
                h_a = 5'd0;
            end
            else
            begin
                skip5 = 5'(-start_y);
                h_a   = (hcell > skip5) ? hcell - skip5 : 5'd0;
            end
        end
        ylim   = $signed({2'b0, surface_height});
        room   = ylim - $signed({2'b0, y_top});
        bottom = $signed({2'b0, y_top}) + 13'(h_a);
        vis    = h_a;
        if (h_a != 5'd0 && bottom > ylim)
        begin
            vis = (room <= 0) ? 5'd0 : 5'(room);
        end
    end

    logic signed [13:0] adv, padv, reach;
    logic signed [12:0] sat_a, sat_p;
    logic [2:0]         bpp;
    always_comb
    begin
        adv   = 14'(pen_reg) + 14'(space_width);
        padv  = 14'(pen_reg) + $signed({9'b0, w_rdata}) + 14'(space_width);
        reach = 14'(pen_reg) + $signed({9'b0, w_rdata});
        sat_a = (adv < 14'(PEN_MIN)) ? PEN_MIN :
                (adv > 14'(PEN_MAX)) ? PEN_MAX : adv[12:0];
        sat_p = (padv < 14'(PEN_MIN)) ? PEN_MIN :
                (padv > 14'(PEN_MAX)) ? PEN_MAX : padv[12:0];
        bpp = (w_rdata > 5'd12) ? 3'd4 : (w_rdata > 5'd8) ? 3'd3 :
              (w_rdata > 5'd4) ? 3'd2 : 3'd1;
    end

    always_comb
    begin
        pend_next = pend_reg;
        pen_next  = pen_reg;
        halt_next = halt_reg;
        job_valid = 1'b0;
        job       = '0;
        job.pen   = pen_reg;
        job.status = 1'b1;
        job.x0    = pen_reg;
        job.y0    = y_top[9:0];
        job.height = vis;
        job.cw    = w_rdata;
        job.bpp   = bpp;
        job.base  = {6'b0, o_rdata} + 18'(bpp) * 18'(skip5);
        if (acc && in_ch.mode == MODE_BEGIN)
        begin
            pen_next  = sx;
            halt_next = 1'b0;
            job_valid = 1'b1;
            job.pen   = sx;
        end
        else if (acc && in_ch.mode == MODE_DRAW)
        begin
            if (halt_reg)
            begin
                job_valid   = 1'b1;
                job.stopped = 1'b1;
            end
            else
            begin
                pend_next = 1'b1;
            end
        end
        if (pend_reg)
        begin
            pend_next = 1'b0;
            job_valid = 1'b1;
            if (vis == 5'd0)
            begin
            end
            else if (w_rdata == 5'd0)
            begin
                pen_next = sat_a;
                job.pen  = sat_a;
            end
            else if (reach > 14'(xend))
            begin
                halt_next   = 1'b1;
                job.stopped = 1'b1;
            end
            else
            begin
                pen_next   = sat_p;
                job.pen    = sat_p;
                job.status = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            pen_reg  <= '0;
            halt_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            pen_reg  <= pen_next;
            halt_reg <= halt_next;
        end
    end
endmodule

// File: src/gsr_queue.sv
// ----------------------------------------------------------------------------
// gsr_queue: two-entry job queue between front and back
// Registered entries, ready while an entry is free.
// ----------------------------------------------------------------------------
module gsr_queue
    import gsr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  gsr_job_t in_job,
    output logic     out_valid,
    input  logic     out_ready,
    output gsr_job_t out_job
);
    gsr_job_t   ent_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_job   = ent_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wp_reg] <= in_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// File: src/gsr_back.sv
// ----------------------------------------------------------------------------
// gsr_back: walks a glyph job, one stored byte per cycle
// Address issue, registered byte read, then color mapping into the output
// register; a skid-free stall holds the whole walk.
// ----------------------------------------------------------------------------
module gsr_back
    import gsr_pkg::*;
#(
    parameter int GLYPH_BYTES = GLYPH_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           job_valid,
    output logic                           job_ready,
    input  gsr_job_t                       job,
    input  logic [31:0]                    color_map,
    input  logic [10:0]                    surface_width,
    input  logic                           byte_we,
    input  logic [11:0]                    byte_waddr,
    input  logic [7:0]                     byte_wdata,
    output logic                           store_idle,
    gsr_out_if.source                      out_ch
);
    localparam int AW = $clog2(GLYPH_BYTES);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } st_t;

    st_t         st_reg, st_next;
    gsr_job_t    cur_reg;
    logic [4:0]  row_reg;
    logic [2:0]  col_reg;
    logic [17:0] addr_reg;
    // byte read stage tag
    logic        rv_reg;
    logic [4:0]  rrow_reg;
    logic [2:0]  rcol_reg;
    logic        rlast_reg;
    logic [7:0]  rdata;
    logic        stall, step, iss_last;
    logic [AW-1:0] raddr;
    logic        wr_ok;

    // output register
    logic               ov_reg;
    logic [9:0]         ox_reg, oy_reg;
    logic [31:0]        opix_reg;
    logic [3:0]         omask_reg;
    logic signed [12:0] open_reg;
    logic               ostop_reg, olast_reg;

    assign out_ch.valid      = ov_reg;
    assign out_ch.pixel_x    = ox_reg;
    assign out_ch.pixel_y    = oy_reg;
    assign out_ch.pixels     = opix_reg;
    assign out_ch.write_mask = omask_reg;
    assign out_ch.pen_x      = open_reg;
    assign out_ch.stopped    = ostop_reg;
    assign out_ch.last       = olast_reg;

    assign stall = ov_reg && !out_ch.ready;

    assign wr_ok = (GLYPH_BYTES >= 4096) ? 1'b1 :
                   ({20'b0, byte_waddr} < 32'(GLYPH_BYTES));
    assign raddr = AW'(addr_reg);

    gsr_ram #(.WIDTH(8), .DEPTH(GLYPH_BYTES)) u_store (
        .clk(clk), .we(byte_we && wr_ok), .waddr(AW'(byte_waddr)),
        .wdata(byte_wdata), .raddr(stall ? AW'(addr_reg - 18'd1) : raddr),
        .rdata(rdata)
    );

    assign iss_last = (row_reg == cur_reg.height - 5'd1) &&
                      (col_reg == cur_reg.bpp - 3'd1);
    assign step     = st_reg == ST_RUN && !stall;
    assign job_ready = st_reg == ST_IDLE && !stall && !rv_reg;
    assign store_idle = st_reg == ST_IDLE && !rv_reg;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (job_valid && job_ready && !job.status)
                begin
                    st_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!stall && iss_last)
                begin
                    st_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!stall)
                begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // map the byte read last cycle
    logic [31:0]        pix;
    logic [3:0]         mask;
    logic signed [13:0] xbase;
    always_comb
    begin
        logic [1:0]         code;
        logic [4:0]         colm;
        logic signed [13:0] x;
        pix   = '0;
        mask  = '0;
        xbase = 14'(cur_reg.x0) + $signed({9'b0, rcol_reg, 2'b00});
        for (int p = 0; p < 4; p++)
        begin
            code = rdata[6-2*p +: 2];
            colm = {rcol_reg, 2'b00} + 5'(p);
            x    = xbase + 14'(p);
            if (code != 2'd0 && colm < cur_reg.cw && x >= 0 &&
                x < $signed({3'b0, surface_width}))
            begin
                mask[p] = 1'b1;
                pix[8*p +: 8] = color_map[8*code +: 8];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && job_ready)
        begin
            cur_reg <= job;
        end
        if (!stall)
        begin
            rrow_reg  <= row_reg;
            rcol_reg  <= col_reg;
            rlast_reg <= iss_last;
        end
        if (job_valid && job_ready)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            addr_reg <= job.base;
        end
        else if (step)
        begin
            addr_reg <= addr_reg + 18'd1;
            if (col_reg == cur_reg.bpp - 3'd1)
            begin
                col_reg <= '0;
                row_reg <= row_reg + 5'd1;
            end
            else
            begin
                col_reg <= col_reg + 3'd1;
            end
        end
        if (!stall)
        begin
            if (rv_reg)
            begin
                ox_reg    <= xbase[9:0];
                oy_reg    <= cur_reg.y0 + 10'(rrow_reg);
                opix_reg  <= pix;
                omask_reg <= mask;
                open_reg  <= cur_reg.pen;
                ostop_reg <= 1'b0;
                olast_reg <= rlast_reg;
            end
            else if (job_valid && job_ready && job.status)
            begin
                ox_reg    <= '0;
                oy_reg    <= '0;
                opix_reg  <= '0;
                omask_reg <= '0;
                open_reg  <= job.pen;
                ostop_reg <= job.stopped;
                olast_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            rv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (!stall)
            begin
                rv_reg <= step;
                ov_reg <= rv_reg || (job_valid && job_ready && job.status);
            end
        end
    end
endmodule

// File: src/glyph_string_rasterizer_unit.sv
// Path: begin and halted-draw results pass the queue and output register; other
//   status results also the table read, glyph results also the address and byte
//   read. Throughput: one result per cycle within a glyph while not stalled; a
//   glyph holds the back part to its end. A draw holds input for its table read,
//   and a glyph byte load waits until the back part and the job queue are idle.
// Reset: asynchronous, active low; pen, halt and registers to defaults.
// ----------------------------------------------------------------------------
// glyph_string_rasterizer_unit: proportional 2 bpp glyph string rasterizer
// Front classifies and clips items, back emits four-pixel results.
// ----------------------------------------------------------------------------
module glyph_string_rasterizer_unit
    import gsr_pkg::*;
#(
    parameter int GLYPH_BYTES = GLYPH_BYTES_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    gsr_in_if.sink      in_ch,
    gsr_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [31:0]        color_map_reg;
    logic signed [10:0] start_x_reg, start_y_reg;
    logic [9:0]         span_reg;
    logic signed [5:0]  space_reg;
    logic [10:0]        surf_w_reg, surf_h_reg;
    logic [4:0]         gh_reg;
    logic               wr;
    logic [2:0]         ridx;

    assign pready = 1'b1;
    assign wr   = psel && penable && pwrite;
    assign ridx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_map_reg <= COLOR_MAP_RST;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            span_reg      <= '0;
            space_reg     <= '0;
            surf_w_reg    <= SURF_W_RST;
            surf_h_reg    <= SURF_H_RST;
            gh_reg        <= GLYPH_H_RST;
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            unique case (ridx)
                REG_COLOR_MAP:    color_map_reg <= pwdata;
                REG_START_X:      start_x_reg   <= pwdata[10:0];
                REG_START_Y:      start_y_reg   <= pwdata[10:0];
                REG_SPAN_WIDTH:   span_reg      <= pwdata[9:0];
                REG_SPACE_WIDTH:  space_reg     <= pwdata[5:0];
                REG_SURF_WIDTH:   surf_w_reg    <= pwdata[10:0];
                REG_SURF_HEIGHT:  surf_h_reg    <= pwdata[10:0];
                REG_GLYPH_HEIGHT: gh_reg        <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (ridx)
            REG_COLOR_MAP:    prdata = color_map_reg;
            REG_START_X:      prdata = {21'b0, start_x_reg};
            REG_START_Y:      prdata = {21'b0, start_y_reg};
            REG_SPAN_WIDTH:   prdata = {22'b0, span_reg};
            REG_SPACE_WIDTH:  prdata = {26'b0, space_reg};
            REG_SURF_WIDTH:   prdata = {21'b0, surf_w_reg};
            REG_SURF_HEIGHT:  prdata = {21'b0, surf_h_reg};
            REG_GLYPH_HEIGHT: prdata = {27'b0, gh_reg};
            default:          prdata = '0;
        endcase
    end

    logic       byte_we;
    logic [11:0] byte_waddr;
    logic [7:0] byte_wdata;
    logic       fj_valid, fj_ready, bj_valid, bj_ready;
    logic       back_idle;
    gsr_job_t   fj, bj;

    gsr_front #(.MAX_ROWS(MAX_ROWS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .start_x(start_x_reg), .start_y(start_y_reg), .span_width(span_reg),
        .space_width(space_reg), .surface_width(surf_w_reg),
        .surface_height(surf_h_reg), .glyph_height(gh_reg),
        .store_idle(back_idle && !bj_valid),
        .byte_we(byte_we), .byte_waddr(byte_waddr), .byte_wdata(byte_wdata),
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    gsr_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(fj_valid), .in_ready(fj_ready), .in_job(fj),
        .out_valid(bj_valid), .out_ready(bj_ready), .out_job(bj)
    );

    gsr_back #(.GLYPH_BYTES(GLYPH_BYTES)) u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(bj_valid), .job_ready(bj_ready),
        .job(bj), .color_map(color_map_reg), .surface_width(surf_w_reg),
        .byte_we(byte_we), .byte_waddr(byte_waddr), .byte_wdata(byte_wdata),
        .store_idle(back_idle), .out_ch(out_ch)
    );
endmodule

// File: tb/sv/gsr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsr_checker: result predictor and scoreboard for the glyph rasterizer
// Watches the register port and both channels, keeps its own copy of the
// tables, pen and registers, and compares every result with the oldest one
// predicted.
// ----------------------------------------------------------------------------
module gsr_checker
    import gsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    gsr_in_if           in_ch,
    gsr_out_if          out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);

    typedef struct packed {
        logic [9:0]  px;
        logic [9:0]  py;
        logic [31:0] pix;
        logic [3:0]  mask;
        logic [12:0] pen;
        logic        stop;
        logic        last;
    } raster_beat_t;

    raster_beat_t beat_q[$];

    logic [4:0]  width_tab [CHAR_COUNT];
    logic [11:0] offset_tab [CHAR_COUNT];
    logic [7:0]  glyph_mem [GLYPH_BYTES_DEF];

    logic [31:0]        color_map_r;
    logic signed [10:0] start_x_r;
    logic signed [10:0] start_y_r;
    logic [9:0]         span_r;
    logic signed [5:0]  space_r;
    logic [10:0]        surf_w_r;
    logic [10:0]        surf_h_r;
    logic [4:0]         glyph_h_r;
    int                 pen_r;
    bit                 halted_r;

    function automatic int clamp_pen(int v);
        if (v < int'(PEN_MIN)) return int'(PEN_MIN);
        if (v > int'(PEN_MAX)) return int'(PEN_MAX);
        return v;
    endfunction

    task automatic push_status(bit stop);
        raster_beat_t r;
        r = '0;
        r.pen = pen_r[12:0];
        r.stop = stop;
        r.last = 1'b1;
        beat_q.push_back(r);
    endtask

    task automatic rasterize_item(logic [2:0] mode, logic [11:0] idx, logic [11:0] val);
        int sx, y, sw, sh, xend, skip, height, bottom, cut, cw, bpp, base, x0;
        int col, xc;
        logic [6:0] c;
        logic [7:0] b;
        logic [1:0] code;
        raster_beat_t r;
        c = idx[6:0];
        case (mode)
            MODE_LOAD_WIDTH:  width_tab[c] = val[4:0];
            MODE_LOAD_OFFSET: offset_tab[c] = val;
            MODE_LOAD_BYTE:   glyph_mem[idx] = val[7:0];
            MODE_BEGIN:
            begin
                pen_r = int'(start_x_r);
                halted_r = 0;
                push_status(0);
            end
            MODE_DRAW:
            begin
                if (halted_r)
                begin
                    push_status(1);
                    return;
                end
                sx = int'(start_x_r);
                y = int'(start_y_r);
                sw = int'(surf_w_r);
                sh = int'(surf_h_r);
                xend = sw;
                skip = 0;
                if (span_r != 0 && sx + int'(span_r) < sw)
                    xend = sx + int'(span_r);
                if (y < 0)
                begin
                    skip = -y;
                    y = 0;
                end
                height = int'(glyph_h_r);
                if (height > MAX_ROWS_DEF) height = MAX_ROWS_DEF;
                height -= skip;
                if (height < 0) height = 0;
                bottom = y + height - 1;
                if (height > 0 && bottom > sh - 1)
                begin
                    cut = bottom - (sh - 1);
                    height -= (cut < height) ? cut : height;
                end
                if (height <= 0)
                begin
                    push_status(0);
                    return;
                end
                cw = int'(width_tab[c]);
                if (cw == 0)
                begin
                    pen_r = clamp_pen(pen_r + int'(space_r));
                    push_status(0);
                    return;
                end
                if (pen_r + cw > xend)
                begin
                    halted_r = 1;
                    push_status(1);
                    return;
                end
                bpp = cw > 12 ? 4 : cw > 8 ? 3 : cw > 4 ? 2 : 1;
                base = int'(offset_tab[c]) + bpp * skip;
                x0 = pen_r;
                pen_r = clamp_pen(pen_r + cw + int'(space_r));
                for (int i = 0; i < height; i++)
                begin
                    for (int j = 0; j < bpp; j++)
                    begin
                        b = glyph_mem[(base + i * bpp + j) % GLYPH_BYTES_DEF];
                        r = '0;
                        for (int p = 0; p < 4; p++)
                        begin
                            code = b[7 - 2 * p -: 2];
                            col = 4 * j + p;
                            xc = x0 + col;
                            if (code != 0 && col < cw && xc >= 0 && xc < sw)
                            begin
                                r.mask[p] = 1'b1;
                                r.pix[8 * p +: 8] = color_map_r[8 * code +: 8];
                            end
                        end
                        r.px = 10'(x0 + 4 * j);
                        r.py = 10'(y + i);
                        r.pen = pen_r[12:0];
                        r.last = (i == height - 1) && (j == bpp - 1);
                        beat_q.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic int check_field(string name, longint want, longint got);
        if (want == got) return 0;
        $display("%0t: mismatch on %s: expected 0x%0h, actual 0x%0h", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        raster_beat_t exp_b;
        int bad;
        if (!rst_n)
        begin
            color_map_r = COLOR_MAP_RST;
            start_x_r = '0;
            start_y_r = '0;
            span_r = '0;
            space_r = '0;
            surf_w_r = SURF_W_RST;
            surf_h_r = SURF_H_RST;
            glyph_h_r = GLYPH_H_RST;
            pen_r = 0;
            halted_r = 0;
            fail_count <= 0;
            pending <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_COLOR_MAP:    color_map_r = pwdata;
                    REG_START_X:      start_x_r = pwdata[10:0];
                    REG_START_Y:      start_y_r = pwdata[10:0];
                    REG_SPAN_WIDTH:   span_r = pwdata[9:0];
                    REG_SPACE_WIDTH:  space_r = pwdata[5:0];
                    REG_SURF_WIDTH:   surf_w_r = pwdata[10:0];
                    REG_SURF_HEIGHT:  surf_h_r = pwdata[10:0];
                    REG_GLYPH_HEIGHT: glyph_h_r = pwdata[4:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                rasterize_item(in_ch.mode, in_ch.index, in_ch.value);
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen <= results_seen + 1;
                if (beat_q.size() == 0)
                begin
                    $display("%0t: result with none expected: x=%0d y=%0d pixels=0x%h",
                             $time, out_ch.pixel_x, out_ch.pixel_y, out_ch.pixels);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_b = beat_q.pop_front();
                    bad = check_field("pixel_x", exp_b.px, out_ch.pixel_x)
                        + check_field("pixel_y", exp_b.py, out_ch.pixel_y)
                        + check_field("pixels", exp_b.pix, out_ch.pixels)
                        + check_field("write_mask", exp_b.mask, out_ch.write_mask)
                        + check_field("pen_x", exp_b.pen, $unsigned(out_ch.pen_x))
                        + check_field("stopped", exp_b.stop, out_ch.stopped)
                        + check_field("last", exp_b.last, out_ch.last);
                    if (bad != 0)
                        fail_count <= fail_count + 1;
                end
            end
            pending <= beat_q.size();
        end
    end

endmodule

// File: tb/sv/tb_glyph_string_rasterizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glyph_string_rasterizer_unit: stimulus and verdict for the rasterizer
// Fills the font tables, then runs directed and random strings under a series
// of register settings, with bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module tb_glyph_string_rasterizer_unit;
    import gsr_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          results_seen;
    int          items_sent;
    int          burst_left;
    int          cycle_count;
    int          stall_left;
    int          stall_style;

    gsr_in_if  in_ch ();
    gsr_out_if out_ch ();

    glyph_string_rasterizer_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    gsr_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count, pending);
            $display("status: fail");
            $finish;
        end
    end

    // result side: change stall style every so often
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 120);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_style)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= $urandom_range(0, 1);
            2: out_ch.ready <= (cycle_count % 4) == 0;
            default: out_ch.ready <= $urandom_range(0, 9) == 0;
        endcase
    end

    task automatic send_item(logic [2:0] mode, logic [11:0] idx, logic [11:0] val);
        in_ch.valid <= 1'b1;
        in_ch.mode <= mode;
        in_ch.index <= idx;
        in_ch.value <= val;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        items_sent++;
        if (burst_left == 0)
        begin
            // hold off for a gap, then start a new burst
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        else
            burst_left--;
    endtask

    // drop valid and wait until every predicted result is back
    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] reg_idx, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic draw(logic [6:0] c);
        send_item(MODE_DRAW, {5'($urandom), c}, 12'($urandom));
    endtask

    // draw one of the filled codes: 0..10 and the last code
    task automatic draw_any();
        if ($urandom_range(0, 11) == 11)
            draw(7'h7F);
        else
            draw(7'($urandom_range(0, 10)));
    endtask

    task automatic random_strings(int count);
        int n;
        n = 0;
        while (n < count)
        begin
            send_item(MODE_BEGIN, 12'($urandom), 12'($urandom));
            n++;
            repeat ($urandom_range(3, 12))
            begin
                case ($urandom_range(0, 19))
                    0: send_item(MODE_LOAD_WIDTH, 12'($urandom), 12'($urandom));
                    1: send_item(MODE_LOAD_OFFSET, 12'($urandom),
                                 12'($urandom_range(0, 31)));
                    2: send_item(MODE_LOAD_BYTE, 12'($urandom), 12'($urandom));
                    3: send_item(3'($urandom_range(5, 7)), 12'($urandom), 12'($urandom));
                    default: draw_any();
                endcase
                n++;
            end
        end
    endtask

    task automatic set_all(logic [31:0] cmap, int sx, int sy, int span, int space,
                           int sw, int sh, int gh);
        write_reg(REG_COLOR_MAP, cmap);
        write_reg(REG_START_X, 32'(sx));
        write_reg(REG_START_Y, 32'(sy));
        write_reg(REG_SPAN_WIDTH, 32'(span));
        write_reg(REG_SPACE_WIDTH, 32'(space));
        write_reg(REG_SURF_WIDTH, 32'(sw));
        write_reg(REG_SURF_HEIGHT, 32'(sh));
        write_reg(REG_GLYPH_HEIGHT, 32'(gh));
    endtask

    initial
    begin
        int widths[10] = '{1, 4, 5, 8, 9, 12, 13, 16, 17, 31};
        int settings;
        int code;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_BEGIN;
        in_ch.index = '0;
        in_ch.value = '0;
        out_ch.ready = 1'b0;
        items_sent = 0;
        burst_left = 0;
        cycle_count = 0;
        stall_left = 0;
        stall_style = 0;
        settings = 1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the codes in use; offsets stay low so every glyph byte read
        // falls inside the filled part of the store
        for (int c = 0; c < 12; c++)
        begin
            code = (c == 11) ? 127 : c;
            if (c == 0)
                send_item(MODE_LOAD_WIDTH, 12'(code), 12'd0);
            else if (c <= 10)
                send_item(MODE_LOAD_WIDTH, 12'(code), 12'(widths[c - 1]));
            else
                send_item(MODE_LOAD_WIDTH, 12'(code), 12'($urandom));
            send_item(MODE_LOAD_OFFSET, {5'($urandom), 7'(code)},
                      12'($urandom_range(0, 31)));
        end
        for (int a = 0; a < 96; a++)
            send_item(MODE_LOAD_BYTE, 12'(a), 12'($urandom));

        // directed: every width class, unknown modes, last code
        send_item(MODE_BEGIN, 12'd0, 12'd0);
        for (int c = 0; c <= 10; c++)
            draw(7'(c));
        draw(7'h7F);
        send_item(3'd5, 12'hFFF, 12'hFFF);
        send_item(3'd6, 12'h000, 12'h000);
        send_item(3'd7, 12'hA5A, 12'h5A5);
        send_item(MODE_BEGIN, 12'hFFF, 12'hFFF);
        // draw the widest code repeatedly; the pen stays short of the right limit
        repeat (9) draw(7'd10);

        // hold input until the block is empty before the next phase
        drain();
        random_strings(8);

        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            settings++;
            case (ph)
                0: set_all($urandom, -6, -3, 0, 0, 320, 200, 16);
                1: set_all($urandom, 1023, 1023, 1023, -32, 1024, 1024, 31);
                2: set_all($urandom, -1024, -1024, 1, 31, 1, 1, 0);
                3: set_all($urandom, 0, 190, 40, 2, 64, 200, 16);
                4: set_all(32'hFFFF_FFFF, -20, 5, 1023, 1, 1024, 20, 16);
                5: set_all(32'h0000_0000, 0, 0, 0, 0, 320, 200, 1);
                default: set_all($urandom, $urandom_range(0, 2047), $urandom_range(0, 2047),
                                 $urandom_range(0, 1023), $urandom_range(0, 63),
                                 $urandom_range(1, 1024), $urandom_range(1, 1024),
                                 $urandom_range(0, 31));
            endcase
            if (ph == 3)
            begin
                send_item(MODE_BEGIN, 12'd0, 12'd0);
                for (int c = 1; c <= 10; c++)
                    draw(7'(c));
            end
            random_strings(8);
        end

        // push the pen to both saturation points with empty glyphs
        drain();
        settings++;
        set_all($urandom, 1023, 0, 0, 31, 320, 200, 4);
        send_item(MODE_LOAD_WIDTH, 12'd0, 12'd0);
        send_item(MODE_BEGIN, 12'd0, 12'd0);
        repeat (104) draw(7'd0);
        drain();
        write_reg(REG_START_X, 32'h0000_0400);
        write_reg(REG_SPACE_WIDTH, 32'h20);
        send_item(MODE_BEGIN, 12'd0, 12'd0);
        repeat (36) draw(7'd0);

        drain();
        $display("covered %0d items and %0d results over %0d register settings",
                 items_sent, results_seen, settings);
        $display("including clipping, halting, pen saturation and unknown modes");
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
src/gsr_pkg.sv
src/gsr_if.sv
src/gsr_ram.sv
src/gsr_front.sv
src/gsr_queue.sv
src/gsr_back.sv
src/glyph_string_rasterizer_unit.sv
tb/sv/gsr_checker.sv
tb/sv/tb_glyph_string_rasterizer_unit.sv
